@@ src/boot_record_crc_validator_macros.svh @@
// ---------------------------------------------------------------------------
// Boot record CRC validator assertion macros
// Shared concurrent assertion forms used by the validator RTL.
// ---------------------------------------------------------------------------
`ifndef BOOT_RECORD_CRC_VALIDATOR_MACROS_SVH
`define BOOT_RECORD_CRC_VALIDATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BRCV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BRCV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/brcv_pkg.sv @@
// ---------------------------------------------------------------------------
// Boot record CRC validator package
// Shared types, constants, the byte-wise CRC-32 step and the byte lane helper.
// ---------------------------------------------------------------------------
package brcv_pkg;

   // record limits
   localparam int MAX_RECORD_BYTES = 256;
   localparam int POS_W            = $clog2(MAX_RECORD_BYTES + 1);
   localparam int CMP_W            = ((POS_W > 8) ? POS_W : 8) + 2;

   // CRC-32, reflected form
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

   // register map, word index taken from paddr[3:2]
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_MAGIC_VALUE  = 2'd0,
      REG_MAGIC_OFFSET = 2'd1,
      REG_CRC_LENGTH   = 2'd2
   } reg_index_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [31:0] magic_value;
      logic [7:0]  magic_offset;
      logic [7:0]  crc_length;
   } cfg_type;

   // one registered input transaction
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } item_type;

   // one CRC byte step: xor in the byte, then eight shift/reduce steps
   function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // replace one byte lane of a little-endian word
   function automatic logic [31:0] put_lane(input logic [31:0] word, input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] w;
      w = word;
      case (lane)
         2'd0: w[7:0]   = b;
         2'd1: w[15:8]  = b;
         2'd2: w[23:16] = b;
         2'd3: w[31:24] = b;
         default: w = word;
      endcase
      return w;
   endfunction

endpackage

@@ src/brcv_csr.sv @@
// ---------------------------------------------------------------------------
// Boot record CRC validator register block
// APB-style configuration registers: magic value, magic offset, CRC length.
// ---------------------------------------------------------------------------
module brcv_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [brcv_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output brcv_pkg::cfg_type                cfg
);
   import brcv_pkg::*;

   logic [31:0]   magic_value_ff;
   logic [7:0]    magic_offset_ff;
   logic [7:0]    crc_length_ff;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = reg_index_type'(paddr[3:2]);

   // register writes; addresses past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_value_ff  <= '0;
         magic_offset_ff <= '0;
         crc_length_ff   <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_MAGIC_VALUE:  magic_value_ff  <= pwdata;
            REG_MAGIC_OFFSET: magic_offset_ff <= pwdata[7:0];
            REG_CRC_LENGTH:   crc_length_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_MAGIC_VALUE:  prdata = magic_value_ff;
         REG_MAGIC_OFFSET: prdata = {24'd0, magic_offset_ff};
         REG_CRC_LENGTH:   prdata = {24'd0, crc_length_ff};
         default:          prdata = '0;
      endcase
   end

   assign cfg.magic_value  = magic_value_ff;
   assign cfg.magic_offset = magic_offset_ff;
   assign cfg.crc_length   = crc_length_ff;

endmodule

@@ src/brcv_input_stage.sv @@
// ---------------------------------------------------------------------------
// Boot record CRC validator input stage
// Registers one incoming byte transaction ahead of the check logic.
// ---------------------------------------------------------------------------
module brcv_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic                advance,
   output brcv_pkg::item_type  item
);
   import brcv_pkg::*;

   logic       valid_ff;
   logic [7:0] data_ff;
   logic       last_ff;

   // free when empty or when the held byte moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         valid_ff <= 1'b1;
      end else if (advance) begin
         valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data_byte;
         last_ff <= req_last_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;
   assign item.last  = last_ff;

endmodule

@@ src/brcv_check.sv @@
// ---------------------------------------------------------------------------
// Boot record CRC validator check stage
// Per-byte CRC, magic and stored CRC capture, and the result register.
// ---------------------------------------------------------------------------
`include "boot_record_crc_validator_macros.svh"

module brcv_check (
   input  logic                clock,
   input  logic                reset,
   input  brcv_pkg::item_type  item,
   input  brcv_pkg::cfg_type   cfg,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_record_valid,
   output logic                rsp_magic_match,
   output logic                rsp_crc_match,
   output logic [31:0]         rsp_computed_crc
);
   import brcv_pkg::*;

   // record state
   logic [31:0]      crc_ff,    crc_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [31:0]      magic_ff,  magic_in;
   logic [31:0]      stored_ff, stored_in;
   logic [2:0]       seen_ff,   seen_in;

   // result register
   logic             rsp_valid_ff;
   logic             record_valid_ff, magic_match_ff, crc_match_ff;
   logic [31:0]      computed_crc_ff;

   logic             in_range;
   logic [CMP_W-1:0] pos_x, off_x, len_x, mag_rel, sto_rel;
   logic             mag_hit, sto_hit, covered;
   logic [31:0]      computed;
   logic             magic_ok, crc_ok, finish;

   // a byte moves on unless it is final and the result slot stays full
   assign advance = item.valid && (!item.last || !rsp_valid_ff || rsp_ready);
   assign finish  = advance && item.last;

   // position tests against the configured offsets
   assign in_range = pos_ff < POS_W'(MAX_RECORD_BYTES);
   assign pos_x    = CMP_W'(pos_ff);
   assign off_x    = CMP_W'(cfg.magic_offset);
   assign len_x    = CMP_W'(cfg.crc_length);
   assign mag_rel  = pos_x - off_x;
   assign sto_rel  = pos_x - len_x;
   assign covered  = pos_x < len_x;
   assign mag_hit  = (pos_x >= off_x) && (mag_rel < CMP_W'(4));
   assign sto_hit  = (pos_x >= len_x) && (sto_rel < CMP_W'(4));

   // next state for the byte in the input register
   always_comb begin
      crc_in    = crc_ff;
      pos_in    = pos_ff;
      magic_in  = magic_ff;
      stored_in = stored_ff;
      seen_in   = seen_ff;
      if (in_range) begin
         if (covered) begin
            crc_in = crc_byte(crc_ff, item.data);
         end
         if (mag_hit) begin
            magic_in = put_lane(magic_ff, mag_rel[1:0], item.data);
         end
         if (sto_hit) begin
            stored_in = put_lane(stored_ff, sto_rel[1:0], item.data);
            if (seen_ff < 3'd4) begin
               seen_in = seen_ff + 3'd1;
            end
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   // verdict for a final byte
   assign computed = ~crc_in;
   assign magic_ok = (CMP_W'(pos_in) >= (off_x + CMP_W'(4))) && (magic_in == cfg.magic_value);
   assign crc_ok   = (seen_in >= 3'd4) && (stored_in == computed);

   // state update; a final byte returns the record state to reset
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         crc_ff    <= CRC_PRESET;
         pos_ff    <= '0;
         magic_ff  <= '0;
         stored_ff <= '0;
         seen_ff   <= '0;
      end else if (advance) begin
         crc_ff    <= crc_in;
         pos_ff    <= pos_in;
         magic_ff  <= magic_in;
         stored_ff <= stored_in;
         seen_ff   <= seen_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (finish) begin
         record_valid_ff <= magic_ok && crc_ok;
         magic_match_ff  <= magic_ok;
         crc_match_ff    <= crc_ok;
         computed_crc_ff <= computed;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_valid = record_valid_ff;
   assign rsp_magic_match  = magic_match_ff;
   assign rsp_crc_match    = crc_match_ff;
   assign rsp_computed_crc = computed_crc_ff;

   // checks
   `BRCV_ASSERT_NEXT(a_clear_after_last, clock, reset, finish, (pos_ff == '0) && (seen_ff == '0) && (crc_ff == CRC_PRESET), "record state not cleared after final byte")
   `BRCV_ASSERT_NOW(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(finish), "result raised without a final byte")
   `BRCV_ASSERT_NEXT(a_pos_step, clock, reset, advance && !item.last && in_range, pos_ff == $past(pos_ff) + 1'b1, "byte position did not step")
   `BRCV_ASSERT_NOW(a_seen_bound, clock, reset, advance, (seen_ff <= 3'd4) && (pos_ff <= POS_W'(MAX_RECORD_BYTES)), "record counters out of bounds")

endmodule

@@ src/boot_record_crc_validator.sv @@
// A final byte passes the input register and then the result register.
// One byte per cycle unless a final byte waits; the CRC step is combinational.
// A final byte waits in the input register only while a result is still untaken.
// Reset (synchronous, active high) clears config, valid flags and record state.
// ---------------------------------------------------------------------------
// Boot record CRC validator
// Streams record bytes, checks CRC-32 and magic word, reports per record.
// ---------------------------------------------------------------------------
module boot_record_crc_validator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_record_valid,
   output logic                             rsp_magic_match,
   output logic                             rsp_crc_match,
   output logic [31:0]                      rsp_computed_crc,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [brcv_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import brcv_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     advance;

   // configuration registers
   brcv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register
   brcv_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .item          (item)
   );

   // check logic and result register
   brcv_check u_check (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .cfg              (cfg),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_record_valid (rsp_record_valid),
      .rsp_magic_match  (rsp_magic_match),
      .rsp_crc_match    (rsp_crc_match),
      .rsp_computed_crc (rsp_computed_crc)
   );

endmodule
